// ===== hdl/vector_terminal_plot_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the vector terminal plot encoder
// Clocked, reset-qualified implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef VECTOR_TERMINAL_PLOT_ENCODER_ASSERT_SVH
`define VECTOR_TERMINAL_PLOT_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define VTPE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vtpe assertion failed");

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define VTPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vtpe assertion failed");

`endif

// ===== hdl/vtpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector terminal plot encoder package
// Shared command codes, queue item type and sizing constants.
// ----------------------------------------------------------------------------
package vtpe_pkg;

  localparam int unsigned ByteW     = 7;
  localparam int unsigned MaxBytes  = 9;
  localparam int unsigned CntW      = $clog2(MaxBytes + 1);
  localparam int unsigned IdxW      = $clog2(MaxBytes);
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned AddrW     = 3;

  typedef enum logic [2:0] {
    CmdMove    = 3'd0,
    CmdPenDown = 3'd1,
    CmdPenUp   = 3'd2,
    CmdFrame   = 3'd3,
    CmdStart   = 3'd4,
    CmdFinish  = 3'd5
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [8:0] x;
    logic [7:0] y;
  } item_t;

endpackage

// ===== hdl/vtpe_front.sv =====
// ----------------------------------------------------------------------------
// Vector terminal plot encoder front end
// Accepts input beats, decodes the command and scales the target to pixels.
// ----------------------------------------------------------------------------
module vtpe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      cmd_i,
  input  logic [15:0]     x_raw_i,
  input  logic [15:0]     y_raw_i,
  output logic            item_valid_o,
  input  logic            item_ready_i,
  output vtpe_pkg::item_t item_o
);

  // Reciprocals of 3 (shift 25) and 1000 (shift 33), exact over the ranges used.
  localparam logic [23:0] RecipThree    = 24'd11184811;
  localparam logic [23:0] RecipThousand = 24'd8589935;

  logic adv;
  logic v1_q, v2_q, v3_q;
  vtpe_pkg::cmd_e cmd1_q, cmd2_q;
  logic [22:0] t1_q;
  logic [21:0] v1_data_q;
  logic [13:0] qx2_q;
  logic [12:0] qy2_q;
  vtpe_pkg::item_t item3_q;

  logic [47:0] px_prod;
  logic [21:0] y_lin;
  logic [22:0] u_sum;
  logic [46:0] qx_prod;
  logic [45:0] qy_prod;

  assign adv          = !v3_q || item_ready_i;
  assign in_ready_o   = adv;
  assign item_valid_o = v3_q;
  assign item_o       = item3_q;

  assign px_prod = 48'({x_raw_i, 8'h00}) * 48'(RecipThree);
  assign y_lin   = 22'({y_raw_i, 5'b0}) + 22'({y_raw_i, 4'b0}) + 22'd500;
  assign u_sum   = t1_q + 23'd500;
  assign qx_prod = 47'(u_sum) * 47'(RecipThousand);
  assign qy_prod = 46'(v1_data_q) * 46'(RecipThousand);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd1_q       <= vtpe_pkg::cmd_e'(cmd_i);
      t1_q         <= px_prod[47:25];
      v1_data_q    <= y_lin;
      cmd2_q       <= cmd1_q;
      qx2_q        <= qx_prod[46:33];
      qy2_q        <= qy_prod[45:33];
      item3_q.cmd  <= cmd2_q;
      item3_q.x    <= (qx2_q > 14'd511) ? 9'd511 : qx2_q[8:0];
      item3_q.y    <= (qy2_q > 13'd249) ? 8'd249 : qy2_q[7:0];
    end
  end

endmodule

// ===== hdl/vtpe_fifo.sv =====
// ----------------------------------------------------------------------------
// Vector terminal plot encoder command queue
// Short first-in first-out queue between the front end and the byte encoder.
// ----------------------------------------------------------------------------
module vtpe_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            ready_o,
  input  vtpe_pkg::item_t data_i,
  output logic            valid_o,
  input  logic            pop_i,
  output vtpe_pkg::item_t data_o
);

  vtpe_pkg::item_t mem_q [vtpe_pkg::FifoDepth];
  logic [vtpe_pkg::PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [vtpe_pkg::PtrW:0]   count_q;
  logic do_push, do_pop;

  assign ready_o = (count_q != (vtpe_pkg::PtrW + 1)'(vtpe_pkg::FifoDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/vtpe_back.sv =====
// ----------------------------------------------------------------------------
// Vector terminal plot encoder back end
// Holds the terminal state, builds the byte run of each command and drains it.
// ----------------------------------------------------------------------------
module vtpe_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       quiet_finish_i,
  input  logic                       item_valid_i,
  output logic                       item_ready_o,
  input  vtpe_pkg::item_t            item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [vtpe_pkg::ByteW-1:0] out_byte_o,
  output logic                       out_last_o
);

  localparam logic [6:0] ByteAlpha    = 7'h1F;
  localparam logic [6:0] ByteVector   = 7'h1D;
  localparam logic [6:0] BytePoint    = 7'h1C;
  localparam logic [6:0] ByteClrText  = 7'h1A;
  localparam logic [6:0] ByteClrScrn  = 7'h19;
  localparam logic [6:0] TagHi        = 7'h20;
  localparam logic [6:0] TagLoX       = 7'h40;
  localparam logic [6:0] TagLoY       = 7'h60;

  typedef enum logic [1:0] {
    ModeAlpha  = 2'd0,
    ModeVector = 2'd1,
    ModePoint  = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [4:0] shx;
    logic [3:0] shy;
    logic [5:0] sly;
    logic [8:0] penx;
    logic [7:0] peny;
    logic [8:0] bx;
    logic [7:0] by;
    logic       bk;
    logic       pd;
    logic       pend;
  } st_t;

  typedef struct packed {
    st_t st;
    logic [vtpe_pkg::MaxBytes-1:0][vtpe_pkg::ByteW-1:0] list;
    logic [vtpe_pkg::CntW-1:0] cnt;
  } work_t;

  function automatic work_t put(work_t w, logic [6:0] b);
    if (w.cnt < vtpe_pkg::CntW'(vtpe_pkg::MaxBytes)) begin
      w.list[w.cnt[vtpe_pkg::IdxW-1:0]] = b;
      w.cnt = w.cnt + 1'b1;
    end
    return w;
  endfunction

  function automatic work_t forget_sent(work_t w);
    w.st.shx = 5'd31;
    w.st.shy = 4'd15;
    w.st.sly = 6'd63;
    return w;
  endfunction

  function automatic work_t enter_mode(work_t w, mode_e m, logic [6:0] b);
    if (w.st.mode != m) begin
      w.st.mode = m;
      w = put(w, b);
      if (m != ModeAlpha) begin
        w = forget_sent(w);
      end
    end
    return w;
  endfunction

  function automatic work_t send_pen(work_t w);
    logic [2:0] hy;
    logic [4:0] ly;
    logic [3:0] hx;
    logic [4:0] lx;
    hy = w.st.peny[7:5];
    ly = w.st.peny[4:0];
    hx = w.st.penx[8:5];
    lx = w.st.penx[4:0];
    if ({1'b0, hy} != w.st.shy) begin
      w.st.shy = {1'b0, hy};
      w = put(w, TagHi | {4'b0, hy});
    end
    if ({1'b0, hx} != w.st.shx) begin
      w.st.sly = {1'b0, ly};
      w = put(w, TagLoY | {2'b0, ly});
      w.st.shx = {1'b0, hx};
      w = put(w, TagHi | {3'b0, hx});
    end else if ({1'b0, ly} != w.st.sly) begin
      w.st.sly = {1'b0, ly};
      w = put(w, TagLoY | {2'b0, ly});
    end
    w = put(w, TagLoX | {2'b0, lx});
    return w;
  endfunction

  function automatic work_t flush_point(work_t w);
    if (w.st.pend) begin
      w = enter_mode(w, ModePoint, BytePoint);
      w = send_pen(w);
      w.st.bx   = w.st.penx;
      w.st.by   = w.st.peny;
      w.st.bk   = 1'b1;
      w.st.pend = 1'b0;
    end
    return w;
  endfunction

  function automatic work_t clear_screen(work_t w);
    w = enter_mode(w, ModeVector, ByteVector);
    w = put(w, ByteClrScrn);
    w.st.bk = 1'b0;
    return w;
  endfunction

  function automatic work_t begin_frame(work_t w);
    w = clear_screen(w);
    w.st.penx = '0;
    w.st.peny = '0;
    w.st.pd   = 1'b0;
    return w;
  endfunction

  st_t   st_q;
  work_t w;
  logic  busy_q;
  logic [vtpe_pkg::MaxBytes-1:0][vtpe_pkg::ByteW-1:0] buf_q;
  logic [vtpe_pkg::CntW-1:0] len_q, idx_q;
  logic  load_ok, pop, out_acc;

  assign out_valid_o  = busy_q;
  assign out_byte_o   = buf_q[idx_q[vtpe_pkg::IdxW-1:0]];
  assign out_last_o   = (idx_q == (len_q - 1'b1));
  assign out_acc      = busy_q && out_ready_i;
  assign load_ok      = !busy_q || (out_ready_i && out_last_o);
  assign item_ready_o = load_ok;
  assign pop          = item_valid_i && load_ok;

  always_comb begin
    w.st   = st_q;
    w.list = '0;
    w.cnt  = '0;
    unique case (item_i.cmd)
      vtpe_pkg::CmdMove: begin
        if (!w.st.pd) begin
          w = flush_point(w);
          w.st.penx = item_i.x;
          w.st.peny = item_i.y;
        end else begin
          if (w.st.mode != ModeVector || !w.st.bk ||
              w.st.penx != w.st.bx || w.st.peny != w.st.by) begin
            w.st.mode = ModeAlpha;
            w = enter_mode(w, ModeVector, ByteVector);
            w = send_pen(w);
          end
          w.st.penx = item_i.x;
          w.st.bx   = item_i.x;
          w.st.peny = item_i.y;
          w.st.by   = item_i.y;
          w.st.bk   = 1'b1;
          w = send_pen(w);
          w.st.pend = 1'b0;
        end
      end
      vtpe_pkg::CmdPenDown: begin
        w.st.pend = 1'b1;
        w.st.pd   = 1'b1;
      end
      vtpe_pkg::CmdPenUp: begin
        w.st.pd = 1'b0;
      end
      vtpe_pkg::CmdFrame: begin
        w = flush_point(w);
        w = begin_frame(w);
      end
      vtpe_pkg::CmdStart: begin
        w = enter_mode(w, ModeAlpha, ByteAlpha);
        w = put(w, ByteClrText);
        w.st.pend = 1'b0;
        w = begin_frame(w);
      end
      vtpe_pkg::CmdFinish: begin
        w = flush_point(w);
        if (!quiet_finish_i) begin
          w = clear_screen(w);
        end
        w = enter_mode(w, ModeAlpha, ByteAlpha);
      end
      default: begin
        w.st = st_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode <= ModeAlpha;
      st_q.shx  <= 5'd31;
      st_q.shy  <= 4'd15;
      st_q.sly  <= 6'd63;
      st_q.penx <= '0;
      st_q.peny <= '0;
      st_q.bx   <= '0;
      st_q.by   <= '0;
      st_q.bk   <= 1'b0;
      st_q.pd   <= 1'b0;
      st_q.pend <= 1'b0;
      busy_q    <= 1'b0;
      len_q     <= '0;
      idx_q     <= '0;
    end else if (pop) begin
      st_q   <= w.st;
      busy_q <= (w.cnt != '0);
      len_q  <= w.cnt;
      idx_q  <= '0;
    end else if (out_acc) begin
      if (out_last_o) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      buf_q <= w.list;
    end
  end

endmodule

// ===== hdl/vector_terminal_plot_encoder.sv =====
// ----------------------------------------------------------------------------
// Vector terminal plot encoder
// Turns pen commands into graphics-terminal mode and coordinate bytes.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis stream, one command per beat, and the
// terminal bytes leave on the m_axis stream, one byte per beat, with
// m_axis_tlast on the final byte that a command causes. A command that
// causes no byte produces no beat. The APB port holds quiet_finish at
// address 0; pready is always high.
// A command passes the scaling pipeline (two multiplier stages and a clamp
// stage) and a four-entry queue to the byte encoder, which registers the
// command's byte run when it takes the command from the queue. The encoder
// sends one byte per cycle while m_axis_tready is high and takes the next
// command as the last byte of the current one is accepted; a command that
// causes no byte leaves the encoder idle. A run has at most nine bytes.
// Reset clears the terminal state to alpha mode with all sent coordinate
// parts invalid, empties the pipeline and the queue and clears quiet_finish.
// When the receiver stalls, the current byte holds, the queue and pipeline
// fill, and s_axis_tready drops once the pipeline end cannot advance.
// ----------------------------------------------------------------------------
module vector_terminal_plot_encoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // Fields from bit 0: cmd[2:0], x_raw[18:3], y_raw[34:19], zero padding.
  input  logic [39:0]                s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // Fields from bit 0: out_byte[6:0], zero padding.
  output logic [7:0]                 m_axis_tdata,
  output logic                       m_axis_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vtpe_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic quiet_finish_q;
  logic reg_hit;
  logic front_valid, fifo_ready, fifo_valid, back_ready;
  vtpe_pkg::item_t front_item, fifo_item;
  logic [vtpe_pkg::ByteW-1:0] out_byte;

  assign pready  = 1'b1;
  assign reg_hit = !paddr[2];
  assign prdata  = reg_hit ? {31'b0, quiet_finish_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_finish_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      quiet_finish_q <= pwdata[0];
    end
  end

  vtpe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (s_axis_tdata[2:0]),
    .x_raw_i      (s_axis_tdata[18:3]),
    .y_raw_i      (s_axis_tdata[34:19]),
    .item_valid_o (front_valid),
    .item_ready_i (fifo_ready),
    .item_o       (front_item)
  );

  vtpe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .ready_o (fifo_ready),
    .data_i  (front_item),
    .valid_o (fifo_valid),
    .pop_i   (back_ready),
    .data_o  (fifo_item)
  );

  vtpe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .quiet_finish_i (quiet_finish_q),
    .item_valid_i   (fifo_valid),
    .item_ready_o   (back_ready),
    .item_i         (fifo_item),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_byte_o     (out_byte),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_byte};

endmodule

// ===== hdl/vtpe_checker.sv =====
// ----------------------------------------------------------------------------
// Vector terminal plot encoder port checker
// Port-level checks on the output stream and the register port.
// ----------------------------------------------------------------------------
`include "vector_terminal_plot_encoder_assert.svh"

module vtpe_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [7:0]                 m_axis_tdata,
  input logic                       m_axis_tlast,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [vtpe_pkg::AddrW-1:0] paddr,
  input logic [31:0]                pwdata,
  input logic [31:0]                prdata
);

  // A stalled output beat keeps its byte and its last flag.
  `VTPE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // A text clear is never the last byte of its run, since a screen clear follows it.
  `VTPE_ASSERT_IMPL(a_clr_text_not_last, m_axis_tvalid && (m_axis_tdata[6:0] == 7'h1A), !m_axis_tlast)

  // Terminal bytes are seven bits wide.
  `VTPE_ASSERT_IMPL(a_byte_7bit, m_axis_tvalid, !m_axis_tdata[7])

  // A read right after a write of the register returns the written bit.
  `VTPE_ASSERT_IMPL(a_cfg_readback, (psel && penable && pwrite && !paddr[2]) ##1 (psel && !pwrite && !paddr[2]), (prdata[0] == $past(pwdata[0])) && (prdata[31:1] == 31'b0))

endmodule

bind vector_terminal_plot_encoder vtpe_checker u_vtpe_checker (.*);

// ===== test/vector_terminal_plot_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// Vector terminal plot encoder testbench
// Sends pen commands on the input stream and checks every terminal byte and
// its tlast flag against a behavioral encoder kept in the testbench. Both
// streams idle at random, and quiet_finish is set between phases over APB.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_terminal_plot_encoder_tb;

  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  localparam logic [1:0] ModeAlpha  = 2'd0;
  localparam logic [1:0] ModeVector = 2'd1;
  localparam logic [1:0] ModePoint  = 2'd2;

  localparam logic [6:0] CodeAlpha       = 7'h1F;
  localparam logic [6:0] CodeVector      = 7'h1D;
  localparam logic [6:0] CodePoint       = 7'h1C;
  localparam logic [6:0] CodeClearText   = 7'h1A;
  localparam logic [6:0] CodeClearScreen = 7'h19;
  localparam logic [6:0] TagHi           = 7'h20;
  localparam logic [6:0] TagLoX          = 7'h40;
  localparam logic [6:0] TagLoY          = 7'h60;

  localparam logic [4:0] NoHiX = 5'd31;
  localparam logic [3:0] NoHiY = 4'd15;
  localparam logic [5:0] NoLoY = 6'd63;

  localparam int unsigned XMax = 511;
  localparam int unsigned YMax = 249;

  localparam logic [vtpe_pkg::AddrW-1:0] QuietFinishAddr = '0;

  localparam int SettleCycles = 30;
  localparam int IdleLimit    = 4000;
  localparam int LongHold     = 400;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] x_raw;
    logic [15:0] y_raw;
  } pen_cmd_t;

  typedef struct packed {
    logic [6:0] code;
    logic       last_flag;
  } term_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // Fields from bit 0: cmd[2:0], x_raw[18:3], y_raw[34:19], zero padding.
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // Fields from bit 0: out_byte[6:0], zero padding.
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [vtpe_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vector_terminal_plot_encoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  pen_cmd_t   pending_cmds[$];
  term_beat_t expected_bytes[$];
  logic [6:0] step_bytes[$];
  int         mismatch_count = 0;

  // Encoder state as the terminal sees it.
  bit         quiet_fin = 1'b0;
  logic [1:0] term_mode = ModeAlpha;
  logic [4:0] sent_hi_x = NoHiX;
  logic [3:0] sent_hi_y = NoHiY;
  logic [5:0] sent_lo_y = NoLoY;
  logic [8:0] pen_x = '0;
  logic [7:0] pen_y = '0;
  logic [8:0] beam_x = '0;
  logic [7:0] beam_y = '0;
  bit         beam_known = 1'b0;
  bit         pen_down = 1'b0;
  bit         point_pending = 1'b0;

  task automatic emit(input logic [6:0] code);
    if (step_bytes.size() < vtpe_pkg::MaxBytes) step_bytes.push_back(code);
  endtask

  task automatic enter_mode(input logic [1:0] mode, input logic [6:0] code);
    if (term_mode != mode) begin
      term_mode = mode;
      emit(code);
      if (mode != ModeAlpha) begin
        sent_hi_x = NoHiX;
        sent_hi_y = NoHiY;
        sent_lo_y = NoLoY;
      end
    end
  endtask

  task automatic send_pen();
    logic [3:0] hy;
    logic [4:0] hx;
    logic [5:0] ly;
    hy = {1'b0, pen_y[7:5]};
    ly = {1'b0, pen_y[4:0]};
    hx = {1'b0, pen_x[8:5]};
    if (hy != sent_hi_y) begin
      sent_hi_y = hy;
      emit(TagHi | 7'(hy));
    end
    if (hx != sent_hi_x) begin
      sent_lo_y = ly;
      emit(TagLoY | 7'(ly));
      sent_hi_x = hx;
      emit(TagHi | 7'(hx));
    end else if (ly != sent_lo_y) begin
      sent_lo_y = ly;
      emit(TagLoY | 7'(ly));
    end
    emit(TagLoX | 7'(pen_x[4:0]));
  endtask

  task automatic flush_point();
    if (point_pending) begin
      enter_mode(ModePoint, CodePoint);
      send_pen();
      beam_x = pen_x;
      beam_y = pen_y;
      beam_known = 1'b1;
      point_pending = 1'b0;
    end
  endtask

  task automatic clear_screen();
    enter_mode(ModeVector, CodeVector);
    emit(CodeClearScreen);
    beam_known = 1'b0;
  endtask

  task automatic begin_frame();
    clear_screen();
    pen_x = '0;
    pen_y = '0;
    pen_down = 1'b0;
  endtask

  task automatic encode_command(input pen_cmd_t c);
    int unsigned xs;
    int unsigned ys;
    step_bytes.delete();
    case (c.cmd)
      vtpe_pkg::CmdMove: begin
        xs = c.x_raw;
        ys = c.y_raw;
        xs = (xs * 256 / 3 + 500) / 1000;
        ys = (ys * 48 + 500) / 1000;
        if (xs > XMax) xs = XMax;
        if (ys > YMax) ys = YMax;
        if (!pen_down) begin
          flush_point();
          pen_x = xs[8:0];
          pen_y = ys[7:0];
        end else begin
          if (term_mode != ModeVector || !beam_known || pen_x != beam_x || pen_y != beam_y)
          begin
            term_mode = ModeAlpha;
            enter_mode(ModeVector, CodeVector);
            send_pen();
          end
          pen_x = xs[8:0];
          pen_y = ys[7:0];
          beam_x = pen_x;
          beam_y = pen_y;
          beam_known = 1'b1;
          send_pen();
          point_pending = 1'b0;
        end
      end
      vtpe_pkg::CmdPenDown: begin
        point_pending = 1'b1;
        pen_down = 1'b1;
      end
      vtpe_pkg::CmdPenUp: pen_down = 1'b0;
      vtpe_pkg::CmdFrame: begin
        flush_point();
        begin_frame();
      end
      vtpe_pkg::CmdStart: begin
        enter_mode(ModeAlpha, CodeAlpha);
        emit(CodeClearText);
        point_pending = 1'b0;
        begin_frame();
      end
      vtpe_pkg::CmdFinish: begin
        flush_point();
        if (!quiet_fin) clear_screen();
        enter_mode(ModeAlpha, CodeAlpha);
      end
      default: ;
    endcase
    foreach (step_bytes[i]) begin
      expected_bytes.push_back('{code: step_bytes[i],
                                 last_flag: (i == step_bytes.size() - 1)});
    end
  endtask

  // Input side: acceptance and prediction at the rising edge.
  bit in_fire = 1'b0;

  always @(posedge clk_i) begin
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_fire) encode_command(pending_cmds.pop_front());
  end

  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, pending_cmds[0].y_raw, pending_cmds[0].x_raw,
                         pending_cmds[0].cmd};
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Output side: stall pattern with an optional long hold.
  bit rx_long_req = 1'b0;
  int rx_hold = 0;
  int rx_span = 0;
  int rx_style = 0;

  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (rx_long_req) begin
      rx_long_req = 1'b0;
      rx_hold = LongHold;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_style = $urandom_range(0, 2);
        rx_span = $urandom_range(16, 96);
      end else begin
        rx_span--;
      end
      case (rx_style)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  term_beat_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual byte %h last %b",
                 $time, m_axis_tdata[6:0], m_axis_tlast);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata[6:0] !== want.code) begin
          $display("%0t: out_byte mismatch, expected %h, actual %h",
                   $time, want.code, m_axis_tdata[6:0]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last_flag) begin
          $display("%0t: last mismatch, expected %b, actual %b",
                   $time, want.last_flag, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  int stall_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= IdleLimit) begin
        $display("%0t: no beat for %0d cycles", $time, stall_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Stimulus.
  logic [15:0] last_x_raw = '0;
  logic [15:0] last_y_raw = '0;

  task automatic push_cmd(input logic [2:0] cmd, input logic [15:0] x_raw,
                          input logic [15:0] y_raw);
    pending_cmds.push_back('{cmd: cmd, x_raw: x_raw, y_raw: y_raw});
    if (cmd == vtpe_pkg::CmdMove) begin
      last_x_raw = x_raw;
      last_y_raw = y_raw;
    end
  endtask

  function automatic logic [15:0] pick_raw(input logic [15:0] prev, input int unsigned span);
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1, 2: return prev;
      3, 4, 5: return prev + 16'($urandom_range(0, 60)) - 16'd30;
      default: return 16'($urandom_range(0, span));
    endcase
  endfunction

  task automatic move_near();
    push_cmd(vtpe_pkg::CmdMove, pick_raw(last_x_raw, 6000), pick_raw(last_y_raw, 5200));
  endtask

  task automatic random_plot(input int count);
    int done;
    int strokes;
    done = 0;
    while (done < count) begin
      case ($urandom_range(0, 19))
        0: begin
          push_cmd(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
          done++;
        end
        1: begin
          push_cmd(vtpe_pkg::CmdFrame, 16'($urandom), 16'($urandom));
          done++;
        end
        2: begin
          push_cmd(vtpe_pkg::CmdStart, 16'($urandom), 16'($urandom));
          done++;
        end
        3: begin
          push_cmd(vtpe_pkg::CmdFinish, 16'($urandom), 16'($urandom));
          done++;
        end
        4: begin
          push_cmd(vtpe_pkg::CmdPenDown, 16'($urandom), 16'($urandom));
          push_cmd(vtpe_pkg::CmdPenUp, 16'($urandom), 16'($urandom));
          done += 2;
        end
        default: begin
          move_near();
          push_cmd(vtpe_pkg::CmdPenDown, 16'($urandom), 16'($urandom));
          strokes = $urandom_range(0, 5);
          repeat (strokes) move_near();
          push_cmd(vtpe_pkg::CmdPenUp, 16'($urandom), 16'($urandom));
          done += strokes + 3;
        end
      endcase
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_quiet_finish(input bit value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= QuietFinishAddr;
    pwdata <= {31'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {31'd0, value}) begin
      $display("%0t: quiet_finish readback mismatch, expected %h, actual %h",
               $time, {31'd0, value}, prdata);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    quiet_fin = value;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_quiet_finish(1'b0);
    push_cmd(vtpe_pkg::CmdFinish, 16'hFFFF, 16'hFFFF);
    push_cmd(vtpe_pkg::CmdStart, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdMove, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdPenDown, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdFinish, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdStart, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdPenDown, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdMove, 16'hFFFF, 16'hFFFF);
    push_cmd(vtpe_pkg::CmdMove, 16'hFFFF, 16'hFFFF);
    push_cmd(vtpe_pkg::CmdMove, 16'd5995, 16'd5197);
    push_cmd(vtpe_pkg::CmdPenUp, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdMove, 16'd1000, 16'd1000);
    push_cmd(vtpe_pkg::CmdPenDown, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdPenUp, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdMove, 16'd3000, 16'd2000);
    push_cmd(vtpe_pkg::CmdPenDown, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdFrame, 16'h0000, 16'h0000);
    push_cmd(CmdSpare6, 16'hA5A5, 16'h5A5A);
    push_cmd(CmdSpare7, 16'hFFFF, 16'h0000);
    push_cmd(vtpe_pkg::CmdPenDown, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdMove, 16'd10, 16'd10);
    push_cmd(vtpe_pkg::CmdPenDown, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdStart, 16'h0000, 16'h0000);
    drain();

    set_quiet_finish(1'b1);
    push_cmd(vtpe_pkg::CmdFinish, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdPenDown, 16'h0000, 16'h0000);
    push_cmd(vtpe_pkg::CmdFinish, 16'h0000, 16'h0000);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      set_quiet_finish(phase[0]);
      if (phase == 1) rx_long_req = 1'b1;
      random_plot(80);
      drain();
    end

    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
